// ===== design/nearest_track_association_unit_assert.svh =====
// assertion macros for the nearest track association unit
`ifndef NEAREST_TRACK_ASSOCIATION_UNIT_ASSERT_SVH
`define NEAREST_TRACK_ASSOCIATION_UNIT_ASSERT_SVH
`ifndef SYNTH
`define NTA_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NTA_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NTA_ASSERT_IMP(label, clk_s, rst_s, ante, cons)
`define NTA_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

// ===== design/nta_pkg.sv =====
// types and constants for the nearest track association unit
`default_nettype none
package nta_pkg;
  localparam logic OP_CLUSTER = 1'b0;
  localparam logic OP_SWEEP   = 1'b1;
  localparam logic [0:0] REG_ASSOC = 1'b0;
  localparam logic [0:0] REG_TIMEOUT = 1'b1;
  typedef struct packed {
    logic               op;
    logic [31:0]        stamp_ms;
    logic signed [15:0] centroid_x;
    logic signed [15:0] centroid_y;
    logic signed [15:0] centroid_z;
  } in_word_t;
  typedef struct packed {
    logic [15:0] match_id;
    logic        new_track;
    logic        table_full;
    logic [6:0]  live_tracks;
  } out_word_t;
endpackage
`default_nettype wire

// ===== design/nearest_track_association_unit.sv =====
// nearest track association unit: track table, scan sequencer, sweep compaction
// cluster word: each live slot goes through S_SCAN, S_CALC and S_SUM; a match then S_WRITE, S_DONE
// sweep word: each live slot goes through S_SWEEP and S_SWCHK, timed-out slots are dropped
// busy stays high from start until the result strobe; one word at a time, no back pressure
// rst clears state, counts and taken marks, sets default regs; track memory holds no reset
`default_nettype none
module nearest_track_association_unit #(
  parameter int MAX_TRACKS = 64
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  output logic                  busy,
  input  wire nta_pkg::in_word_t  in_word,
  output logic                  done,
  output nta_pkg::out_word_t    out_word,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire [2:0]             paddr,
  input  wire [31:0]            pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CW = $clog2(MAX_TRACKS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_SWEEP = 3'd5;
  localparam logic [2:0] S_SWCHK = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [31:0]        seen;
    logic [15:0]        number;
  } track_t;

  logic [2:0]  state;
  logic [14:0] assoc_dist_mm;
  logic [19:0] timeout_ms;
  nta_pkg::in_word_t cur;
  track_t      mem [MAX_TRACKS];
  track_t      rd;
  logic [AW-1:0] rd_addr;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  track_t      wr_data;
  logic [MAX_TRACKS-1:0] taken;
  logic [CW-1:0] live_count;
  logic [15:0] next_number;
  logic [CW-1:0] idx;
  logic [CW-1:0] wptr;
  logic [AW-1:0] rd_slot;
  logic [31:0] sq_a, sq_b, sq_c;
  logic [31:0] best_d2;
  logic [AW-1:0] best;
  logic        found;
  logic [33:0] d2;
  logic signed [16:0] dx, dy, dz;
  logic [16:0] ax, ay, az;
  logic [31:0] age;

  assign pready = 1'b1;
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      assoc_dist_mm <= 15'd250;
      timeout_ms <= 20'd1000;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == nta_pkg::REG_ASSOC && paddr[1:0] == 2'd0) begin
        assoc_dist_mm <= pwdata[14:0];
      end else if (paddr[2] == nta_pkg::REG_TIMEOUT && paddr[1:0] == 2'd0) begin
        timeout_ms <= pwdata[19:0];
      end
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr == 3'd0) begin
      prdata = {17'd0, assoc_dist_mm};
    end else if (paddr == 3'd4) begin
      prdata = {12'd0, timeout_ms};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd <= mem[rd_addr];
  end

  assign dx = 17'(cur.centroid_x) - 17'(rd.x);
  assign dy = 17'(cur.centroid_y) - 17'(rd.y);
  assign dz = 17'(cur.centroid_z) - 17'(rd.z);
  assign ax = dx[16] ? 17'(-dx) : 17'(dx);
  assign ay = dy[16] ? 17'(-dy) : 17'(dy);
  assign az = dz[16] ? 17'(-dz) : 17'(dz);
  assign d2 = 34'(sq_a) + 34'(sq_b) + 34'(sq_c);
  assign age = cur.stamp_ms - rd.seen;

  always_comb begin
    rd_addr = idx[AW-1:0];
    wr_en = 1'b0;
    wr_addr = best;
    wr_data = '{x: cur.centroid_x, y: cur.centroid_y, z: cur.centroid_z,
                seen: cur.stamp_ms, number: rd.number};
    if (state == S_WRITE) begin
      wr_en = found || (live_count < CW'(MAX_TRACKS));
      if (!found) begin
        wr_addr = live_count[AW-1:0];
        wr_data.number = next_number;
      end
    end else if (state == S_SWCHK) begin
      wr_en = (age <= 32'(timeout_ms));
      wr_addr = wptr[AW-1:0];
      wr_data = rd;
    end
    if ((state == S_WRITE && found) || (state == S_SCAN && idx >= live_count)) begin
      rd_addr = best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      taken <= '0;
      live_count <= '0;
      next_number <= '0;
      done <= 1'b0;
      idx <= '0;
      wptr <= '0;
      found <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur <= in_word;
            idx <= '0;
            wptr <= '0;
            found <= 1'b0;
            best <= '0;
            best_d2 <= 32'(assoc_dist_mm) * 32'(assoc_dist_mm);
            if (in_word.op == nta_pkg::OP_SWEEP) begin
              state <= S_SWEEP;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx >= live_count) begin
            state <= S_WRITE;
          end else begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          sq_a <= ax * ax;
          sq_b <= ay * ay;
          sq_c <= az * az;
          rd_slot <= idx[AW-1:0];
          state <= S_SUM;
        end
        S_SUM: begin
          if (!taken[rd_slot] && d2 < 34'(best_d2)) begin
            best_d2 <= d2[31:0];
            best <= rd_slot;
            found <= 1'b1;
          end
          idx <= idx + 1'b1;
          state <= S_SCAN;
        end
        S_WRITE: begin
          out_word.new_track <= 1'b0;
          out_word.table_full <= 1'b0;
          if (found) begin
            taken[best] <= 1'b1;
            state <= S_DONE;
          end else if (live_count < CW'(MAX_TRACKS)) begin
            taken[live_count[AW-1:0]] <= 1'b1;
            out_word.match_id <= next_number;
            out_word.new_track <= 1'b1;
            next_number <= next_number + 1'b1;
            live_count <= live_count + 1'b1;
            out_word.live_tracks <= 7'(live_count + 1'b1);
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            out_word.match_id <= '0;
            out_word.table_full <= 1'b1;
            out_word.live_tracks <= 7'(live_count);
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_DONE: begin
          out_word.match_id <= rd.number;
          out_word.live_tracks <= 7'(live_count);
          done <= 1'b1;
          state <= S_IDLE;
        end
        S_SWEEP: begin
          if (idx >= live_count) begin
            live_count <= wptr;
            taken <= '0;
            out_word.match_id <= '0;
            out_word.new_track <= 1'b0;
            out_word.table_full <= 1'b0;
            out_word.live_tracks <= 7'(wptr);
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_SWCHK;
          end
        end
        S_SWCHK: begin
          if (age <= 32'(timeout_ms)) begin
            wptr <= wptr + 1'b1;
          end
          idx <= idx + 1'b1;
          state <= S_SWEEP;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "nearest_track_association_unit_assert.svh"
  `NTA_ASSERT_IMP(a_done_busy, clk, rst, done, !busy)
  `NTA_ASSERT_IMP(a_live_bound, clk, rst, 1'b1, live_count <= CW'(MAX_TRACKS))
  `NTA_ASSERT_IMP(a_full_excl, clk, rst, done, !(out_word.new_track && out_word.table_full))
  `NTA_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
endmodule
`default_nettype wire

// ===== bench/nta_checker.sv =====
// checker for the nearest track association unit: predicts each result word and compares it
module nta_checker (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire                 busy,
  input  wire nta_pkg::in_word_t  in_word,
  input  wire                 done,
  input  wire nta_pkg::out_word_t out_word,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire                 pready,
  input  wire [2:0]           paddr,
  input  wire [31:0]          pwdata,
  output int                  errors,
  output int                  pending,
  output int                  accepted
);
  import nta_pkg::*;
  localparam int SLOTS = 64;

  logic [14:0] dist_reg;
  logic [19:0] tout_reg;
  logic signed [15:0] tx [SLOTS];
  logic signed [15:0] ty [SLOTS];
  logic signed [15:0] tz [SLOTS];
  logic [31:0] seen [SLOTS];
  logic [15:0] num [SLOTS];
  logic taken [SLOTS];
  logic [15:0] next_num;
  int live;
  out_word_t expected_words[$];
  int sweeps, creates, fulls;

  function automatic logic [33:0] sqd(logic signed [15:0] a, logic signed [15:0] b);
    logic signed [17:0] d;
    logic [16:0] m;
    d = a - b;
    m = d < 0 ? -d : d;
    return m * m;
  endfunction

  task automatic track_step(in_word_t w);
    out_word_t r;
    logic [35:0] best_d2, d2;
    int best, k;
    bit found;
    r = '0;
    if (w.op == OP_SWEEP) begin
      k = 0;
      sweeps++;
      for (int i = 0; i < live; i++) begin
        if (w.stamp_ms - seen[i] <= {12'd0, tout_reg}) begin
          tx[k] = tx[i]; ty[k] = ty[i]; tz[k] = tz[i];
          seen[k] = seen[i]; num[k] = num[i];
          k++;
        end
      end
      live = k;
      for (int i = 0; i < SLOTS; i++) taken[i] = 0;
    end else begin
      best_d2 = dist_reg * dist_reg;
      best = 0;
      found = 0;
      for (int i = 0; i < live; i++) begin
        if (taken[i]) continue;
        d2 = sqd(w.centroid_x, tx[i]) + sqd(w.centroid_y, ty[i]) + sqd(w.centroid_z, tz[i]);
        if (d2 < best_d2) begin
          best_d2 = d2; best = i; found = 1;
        end
      end
      if (!found && live < SLOTS) begin
        best = live;
        num[best] = next_num;
        next_num++;
        live++;
        r.new_track = 1;
        creates++;
        found = 1;
      end
      if (found) begin
        tx[best] = w.centroid_x; ty[best] = w.centroid_y; tz[best] = w.centroid_z;
        seen[best] = w.stamp_ms;
        taken[best] = 1;
        r.match_id = num[best];
      end else begin
        r.table_full = 1;
        fulls++;
      end
    end
    r.live_tracks = live[6:0];
    expected_words.insert(expected_words.size(), r);
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (rst) begin
      dist_reg <= 15'd250;
      tout_reg <= 20'd1000;
      live = 0;
      next_num = 0;
      for (int i = 0; i < SLOTS; i++) taken[i] = 0;
      expected_words.delete();
      errors <= 0;
      accepted <= 0;
      sweeps = 0; creates = 0; fulls = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_ASSOC) dist_reg <= pwdata[14:0];
        else tout_reg <= pwdata[19:0];
      end
      if (done) begin
        if (expected_words.size() == 0) begin
          if (errors < 10) $display("unexpected result word %h", out_word);
          errors <= errors + 1;
        end else begin
          e = expected_words.pop_front();
          if (e !== out_word) begin
            if (errors < 10)
              $display({"mismatch: expected id %0d new %0b full %0b live %0d, ",
                        "got id %0d new %0b full %0b live %0d"},
                       e.match_id, e.new_track, e.table_full, e.live_tracks,
                       out_word.match_id, out_word.new_track, out_word.table_full,
                       out_word.live_tracks);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy) begin
        track_step(in_word);
        accepted <= accepted + 1;
      end
    end
    pending <= expected_words.size();
  end
endmodule

// ===== bench/tb_nearest_track_association_unit.sv =====
// testbench top for the nearest track association unit: stimulus, register writes, verdict
module tb_nearest_track_association_unit;
  import nta_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done, pready;
  in_word_t in_word = '0;
  out_word_t out_word;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int errors, pending, accepted;
  int idle_pct = 33;
  int quiet = 0;
  int last_acc;
  logic [31:0] now_ms = 0;
  logic signed [15:0] hot_x [8];
  logic signed [15:0] hot_y [8];
  logic signed [15:0] hot_z [8];

  always #5 clk = ~clk;

  nearest_track_association_unit DUT (.*);

  nta_checker checker_i (.*);

  always @(posedge clk) begin
    if (rst || accepted != last_acc || done) quiet <= 0;
    else quiet <= quiet + 1;
    last_acc <= accepted;
    if (quiet > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic reg_write(logic [0:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send(in_word_t w);
    @(posedge clk);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1;
    in_word <= w;
    do @(posedge clk); while (busy);
    start <= 0;
  endtask

  task automatic drain;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic in_word_t cluster(logic [31:0] t, logic [15:0] x, logic [15:0] y,
                                       logic [15:0] z);
    in_word_t w;
    w.op = OP_CLUSTER; w.stamp_ms = t;
    w.centroid_x = x; w.centroid_y = y; w.centroid_z = z;
    return w;
  endfunction

  function automatic in_word_t sweep_word(logic [31:0] t);
    in_word_t w;
    w.centroid_x = 16'($urandom);
    w.centroid_y = 16'($urandom);
    w.centroid_z = 16'($urandom);
    w.op = OP_SWEEP; w.stamp_ms = t;
    return w;
  endfunction

  task automatic random_phase(int n, int hot_only);
    int k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(5) == 0) begin
        now_ms = now_ms + $urandom_range(1500);
        send(sweep_word(now_ms));
      end else if (hot_only || $urandom_range(3) != 0) begin
        k = $urandom_range(7);
        hot_x[k] = 16'(hot_x[k] + $signed(16'($urandom_range(300))) - 150);
        hot_y[k] = 16'(hot_y[k] + $signed(16'($urandom_range(300))) - 150);
        hot_z[k] = 16'(hot_z[k] + $signed(16'($urandom_range(300))) - 150);
        send(cluster(now_ms, hot_x[k], hot_y[k], hot_z[k]));
      end else begin
        send(cluster($urandom_range(1) ? now_ms : $urandom, 16'($urandom), 16'($urandom),
                     16'($urandom)));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      hot_x[i] = 16'($urandom); hot_y[i] = 16'($urandom); hot_z[i] = 16'($urandom);
    end
    repeat (2) @(posedge clk);
    rst <= 0;
    send(cluster(32'd0, 16'h7fff, 16'h7fff, 16'h7fff));
    send(cluster(32'd0, 16'h8000, 16'h8000, 16'h8000));
    send(cluster(32'd1, 16'h7fff, 16'h7fff, 16'h7fff));
    send(cluster(32'd1, 16'd0, 16'd0, 16'd0));
    send(cluster(32'd2, 16'd10, 16'd0, 16'd0));
    send(sweep_word(32'd5));
    send(cluster(32'd6, 16'd5, 16'd0, 16'd0));
    send(cluster(32'd6, 16'd5, 16'd0, 16'd0));
    send(cluster(32'hffff_ffff, 16'd0, 16'd0, 16'd0));
    send(sweep_word(32'd2000));
    send(sweep_word(32'hffff_ffff));
    drain();
    reg_write(REG_ASSOC, 32'd0);
    reg_write(REG_TIMEOUT, 32'hfffff);
    for (int i = 0; i < 70; i++) send(cluster(32'd100, 16'd0, 16'd0, 16'd0));
    send(sweep_word(32'd200));
    drain();
    reg_write(REG_ASSOC, 32'h7fff);
    for (int i = 0; i < 66; i++) begin
      send(cluster(32'd300, 16'($urandom), 16'($urandom), 16'($urandom)));
    end
    send(sweep_word(32'd400));
    drain();
    reg_write(REG_TIMEOUT, 32'd0);
    send(sweep_word(32'd401));
    drain();
    reg_write(REG_ASSOC, 32'd250);
    reg_write(REG_TIMEOUT, 32'd1000);
    idle_pct = 0;
    random_phase(200, 1);
    idle_pct = 33;
    random_phase(400, 0);
    drain();
    reg_write(REG_ASSOC, 32'd2000);
    reg_write(REG_TIMEOUT, 32'd3000);
    random_phase(400, 0);
    drain();
    reg_write(REG_ASSOC, 32'd80);
    reg_write(REG_TIMEOUT, 32'd200);
    random_phase(150, 1);
    drain();
    $display("ran %0d words: directed extremes, full table, zero and maximum distances,",
             accepted);
    $display("timeout sweeps with wrap and random frames under several register settings");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/nta_pkg.sv
design/nearest_track_association_unit.sv
bench/nta_checker.sv
bench/tb_nearest_track_association_unit.sv
